// ----- hw/rtl/ssi_pkg.sv -----
// ssi_pkg: shared types and constants of the directive scanner
// scan phases, result kinds, opener characters and the result burst size
// no dependencies
`timescale 1ns / 1ps

package ssi_pkg;

   // scanner phase: held opener prefix, then body with dash tracking
   typedef enum logic [2:0] {
      PH_GROUND  = 3'd0,
      PH_LT      = 3'd1,
      PH_BANG    = 3'd2,
      PH_DASH1   = 3'd3,
      PH_DASH2   = 3'd4,
      PH_BODY    = 3'd5,
      PH_BODY_D1 = 3'd6,
      PH_BODY_D2 = 3'd7
   } phase_type;

   // result kinds
   typedef enum logic [1:0] {
      K_TEXT    = 2'd0,
      K_BODY    = 2'd1,
      K_END     = 2'd2,
      K_ABANDON = 2'd3
   } kind_type;

   // characters of the opener and closer
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_GT   = 8'h3E;

   // most results one input item can cause: four prefix bytes plus the byte
   localparam int MAX_RESULTS = 5;
   localparam int COUNT_W     = 3;

   // byte k of the opener prefix "<!--"
   function automatic logic [7:0] opener_byte(input logic [COUNT_W-1:0] k);
      logic [7:0] b;
      case (k)
         3'd0:    b = CH_LT;
         3'd1:    b = CH_BANG;
         default: b = CH_DASH;
      endcase
      return b;
   endfunction

   // byte expected next while a prefix is held
   function automatic logic [7:0] wanted_byte(input phase_type ph);
      logic [7:0] b;
      case (ph)
         PH_LT:    b = CH_BANG;
         PH_BANG:  b = CH_DASH;
         PH_DASH1: b = CH_DASH;
         default:  b = CH_HASH;
      endcase
      return b;
   endfunction

endpackage

// ----- hw/rtl/ssi_directive_scanner_top.sv -----
// ssi_directive_scanner_top: server side include directive scanner
// depends on ssi_pkg for phases, kinds and character constants
`timescale 1ns / 1ps

// The scanner takes one document byte per cycle, unless a burst of results is
// still draining, and emits text bytes, directive body bytes (the closing dashes
// stripped, the body cut to DIRECTIVE_BYTES-3 bytes), and end or abandoned
// markers. Each accepted item is decoded in the cycle it is accepted into a
// burst buffer of up to five results, which drains one result per cycle while
// rsp_ready is high. A mismatch after a held "<!--" prefix causes five results
// and holds the input until they drain. A new item is taken in the same cycle
// the last result of the burst is taken.
module ssi_directive_scanner_top
   import ssi_pkg::*;
#(
   parameter int DIRECTIVE_BYTES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_last_of_run
);

   localparam int BODY_W = $clog2(DIRECTIVE_BYTES);
   localparam logic [BODY_W-1:0] BODY_MAX = BODY_W'(DIRECTIVE_BYTES - 1);

   // scanner state
   phase_type         phase_ff, phase_in;
   logic [BODY_W-1:0] body_count_ff, body_count_in;
   logic [7:0]        delay0_ff, delay0_in;
   logic [7:0]        delay1_ff, delay1_in;

   // burst buffer
   logic [7:0]         buf_byte_ff [MAX_RESULTS];
   kind_type           buf_kind_ff [MAX_RESULTS];
   logic [COUNT_W-1:0] buf_count_ff;
   logic [COUNT_W-1:0] buf_ptr_ff;

   // decoded results of the offered item
   logic [7:0]         res_byte [MAX_RESULTS];
   kind_type           res_kind [MAX_RESULTS];
   logic [COUNT_W-1:0] res_count;

   logic               req_fire, rsp_fire, buf_empty, buf_last;
   logic [COUNT_W-1:0] held;

   // handshake
   assign buf_empty = (buf_ptr_ff == buf_count_ff);
   assign buf_last  = (buf_ptr_ff + 3'd1 == buf_count_ff);
   assign rsp_valid = !buf_empty;
   assign req_ready = buf_empty || (buf_last && rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign rsp_out_byte    = buf_byte_ff[buf_ptr_ff];
   assign rsp_kind        = buf_kind_ff[buf_ptr_ff];
   assign rsp_last_of_run = buf_last;

   assign held = COUNT_W'(phase_ff);

   // next state and results of the offered item
   always_comb begin
      phase_in      = phase_ff;
      body_count_in = body_count_ff;
      delay0_in     = delay0_ff;
      delay1_in     = delay1_ff;
      res_count     = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_byte[i] = 8'h00;
         res_kind[i] = K_TEXT;
      end

      if (req_end_of_input) begin
         // end of document: abandon an open directive, drop a held prefix
         if (phase_ff == PH_BODY || phase_ff == PH_BODY_D1 || phase_ff == PH_BODY_D2) begin
            res_kind[0] = K_ABANDON;
            res_count   = 3'd1;
         end
         phase_in      = PH_GROUND;
         body_count_in = '0;
         delay0_in     = 8'h00;
         delay1_in     = 8'h00;
      end else begin
         case (phase_ff)
            PH_GROUND: begin
               if (req_data_byte == CH_LT) begin
                  phase_in = PH_LT;
               end else begin
                  res_byte[0] = req_data_byte;
                  res_count   = 3'd1;
               end
            end
            PH_LT, PH_BANG, PH_DASH1, PH_DASH2: begin
               if (req_data_byte == wanted_byte(phase_ff)) begin
                  case (phase_ff)
                     PH_LT:    phase_in = PH_BANG;
                     PH_BANG:  phase_in = PH_DASH1;
                     PH_DASH1: phase_in = PH_DASH2;
                     default: begin
                        phase_in      = PH_BODY;
                        body_count_in = '0;
                        delay0_in     = 8'h00;
                        delay1_in     = 8'h00;
                     end
                  endcase
               end else begin
                  // mismatch: held prefix then the byte as text
                  for (int i = 0; i < MAX_RESULTS; i++) begin
                     if (COUNT_W'(i) < held) begin
                        res_byte[i] = opener_byte(COUNT_W'(i));
                     end else if (COUNT_W'(i) == held) begin
                        res_byte[i] = req_data_byte;
                     end
                  end
                  res_count = held + 3'd1;
                  phase_in  = PH_GROUND;
               end
            end
            default: begin
               if (phase_ff == PH_BODY_D2 && req_data_byte == CH_GT) begin
                  // closing: end marker, held bytes dropped
                  res_kind[0]   = K_END;
                  res_count     = 3'd1;
                  phase_in      = PH_GROUND;
                  body_count_in = '0;
                  delay0_in     = 8'h00;
                  delay1_in     = 8'h00;
               end else begin
                  if (req_data_byte == CH_DASH) begin
                     phase_in = (phase_ff == PH_BODY) ? PH_BODY_D1 : PH_BODY_D2;
                  end else begin
                     phase_in = PH_BODY;
                  end
                  // two-byte delay line, body cut at the size limit
                  if (body_count_ff < BODY_MAX) begin
                     if (|body_count_ff[BODY_W-1:1]) begin
                        res_byte[0] = delay0_ff;
                        res_kind[0] = K_BODY;
                        res_count   = 3'd1;
                     end
                     delay0_in     = delay1_ff;
                     delay1_in     = req_data_byte;
                     body_count_in = body_count_ff + 1'b1;
                  end
               end
            end
         endcase
      end
   end

   // scanner state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_GROUND;
         body_count_ff <= '0;
         delay0_ff     <= 8'h00;
         delay1_ff     <= 8'h00;
      end else if (req_fire) begin
         phase_ff      <= phase_in;
         body_count_ff <= body_count_in;
         delay0_ff     <= delay0_in;
         delay1_ff     <= delay1_in;
      end
   end

   // burst buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_count_ff <= '0;
         buf_ptr_ff   <= '0;
      end else if (req_fire) begin
         buf_count_ff <= res_count;
         buf_ptr_ff   <= '0;
      end else if (rsp_fire) begin
         buf_ptr_ff <= buf_ptr_ff + 3'd1;
      end
   end

   // burst buffer payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_byte_ff[i] <= res_byte[i];
            buf_kind_ff[i] <= res_kind[i];
         end
      end
   end

   // checks
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      buf_ptr_ff <= buf_count_ff && buf_count_ff <= 3'(MAX_RESULTS))
      else $error("burst pointer beyond burst count");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == K_END || rsp_kind == K_ABANDON) |-> rsp_out_byte == 8'h00)
      else $error("marker result carries a byte");

   a_eoi_ground: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_end_of_input |=> phase_ff == PH_GROUND && body_count_ff == '0)
      else $error("scanner not back in ground after end of input");

   a_count_in_body: assert property (@(posedge clock) disable iff (reset)
      body_count_ff != '0 |->
         (phase_ff == PH_BODY || phase_ff == PH_BODY_D1 || phase_ff == PH_BODY_D2))
      else $error("body count held outside a directive");

endmodule

// ----- sim/tb_ssi_directive_scanner_top.sv -----
// tb_ssi_directive_scanner_top: self-checking testbench of the directive scanner
// drives byte items with bursts and gaps, stalls the result side, checks every result
// depends on ssi_pkg and ssi_directive_scanner_top
`timescale 1ns / 1ps

module tb_ssi_directive_scanner_top;
   import ssi_pkg::*;

   localparam int DIR_BYTES   = 1024;
   localparam int IDLE_LIMIT  = 3000;
   localparam int RANDOM_ITEMS = 300;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [7:0] data;
      logic       eoi;
   } doc_item_t;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last;
   } result_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic       rsp_last_of_run;

   // document bytes waiting to be sent, results waiting to arrive
   doc_item_t doc_items[$];
   result_t   expected_results[$];

   // scanner state as predicted
   phase_type  sc_phase = PH_GROUND;
   int         body_kept = 0;
   logic [7:0] held_bytes[2] = '{8'h00, 8'h00};

   int fail_count = 0;
   int accepted_items = 0;
   int results_seen = 0;
   int closed_count = 0;
   int abandoned_count = 0;
   int cut_count = 0;

   ssi_directive_scanner_top #(
      .DIRECTIVE_BYTES(DIR_BYTES)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_input(req_end_of_input),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_kind        (rsp_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predict the results of one accepted item and advance the scanner state
   function automatic void scan_item(input logic [7:0] b, input logic eoi);
      result_t    burst[$];
      logic [7:0] want;
      int         prefix_len;
      if (eoi) begin
         if (sc_phase >= PH_BODY) begin
            burst.push_back('{8'h00, K_ABANDON, 1'b0});
            abandoned_count++;
         end
         sc_phase = PH_GROUND;
         body_kept = 0;
         held_bytes = '{8'h00, 8'h00};
      end else begin
         case (sc_phase)
            PH_GROUND: begin
               if (b == CH_LT) sc_phase = PH_LT;
               else burst.push_back('{b, K_TEXT, 1'b0});
            end
            PH_LT, PH_BANG, PH_DASH1, PH_DASH2: begin
               want = (sc_phase == PH_LT) ? CH_BANG :
                      (sc_phase == PH_DASH2) ? CH_HASH : CH_DASH;
               if (b == want) begin
                  if (sc_phase == PH_DASH2) begin
                     sc_phase = PH_BODY;
                     body_kept = 0;
                     held_bytes = '{8'h00, 8'h00};
                  end else begin
                     sc_phase = phase_type'(sc_phase + 3'd1);
                  end
               end else begin
                  // held prefix goes out first, the byte itself is not rescanned
                  prefix_len = int'(sc_phase);
                  for (int k = 0; k < prefix_len; k++)
                     burst.push_back('{(k == 0) ? CH_LT : (k == 1) ? CH_BANG : CH_DASH,
                                       K_TEXT, 1'b0});
                  burst.push_back('{b, K_TEXT, 1'b0});
                  sc_phase = PH_GROUND;
               end
            end
            default: begin
               if (sc_phase == PH_BODY_D2 && b == CH_GT) begin
                  burst.push_back('{8'h00, K_END, 1'b0});
                  closed_count++;
                  sc_phase = PH_GROUND;
                  body_kept = 0;
                  held_bytes = '{8'h00, 8'h00};
               end else begin
                  if (b == CH_DASH)
                     sc_phase = (sc_phase == PH_BODY) ? PH_BODY_D1 : PH_BODY_D2;
                  else
                     sc_phase = PH_BODY;
                  // body goes out two bytes late, nothing kept past the cut
                  if (body_kept < DIR_BYTES - 1) begin
                     if (body_kept >= 2) burst.push_back('{held_bytes[0], K_BODY, 1'b0});
                     held_bytes[0] = held_bytes[1];
                     held_bytes[1] = b;
                     body_kept++;
                  end else begin
                     cut_count++;
                  end
               end
            end
         endcase
      end
      foreach (burst[i]) begin
         burst[i].last = (i == burst.size() - 1);
         expected_results.push_back(burst[i]);
      end
   endfunction

   // stimulus helpers
   task automatic push_byte(input logic [7:0] b);
      doc_items.push_back('{b, 1'b0});
   endtask

   task automatic push_eoi();
      doc_items.push_back('{8'($urandom_range(0, 255)), 1'b1});
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   function automatic logic [7:0] body_char();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: return CH_DASH;
         3:       return CH_GT;
         4:       return CH_LT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // sender: bursts of items with random gaps, valid held until taken
   doc_item_t next_item;
   int        burst_left = 20;
   int        gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (doc_items.size() > 0) begin
            next_item = doc_items.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_item.data;
            req_end_of_input <= next_item.eoi;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 60);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall modes that change at random intervals, one long hold-off
   int  stall_mode = 0;
   int  mode_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_items >= 120) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 80);
         end
         mode_left--;
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor: predict on accepted items, compare accepted results in order
   result_t head;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            scan_item(req_data_byte, req_end_of_input);
            accepted_items++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: out_byte %0d kind %0d last_of_run %0d",
                      rsp_out_byte, rsp_kind, rsp_last_of_run);
               fail_count++;
            end else begin
               head = expected_results.pop_front();
               if (rsp_out_byte !== head.out_byte) begin
                  $error("out_byte: expected %0d, got %0d", head.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_kind !== head.kind) begin
                  $error("kind: expected %0d, got %0d", head.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_last_of_run !== head.last) begin
                  $error("last_of_run: expected %0d, got %0d", head.last, rsp_last_of_run);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("ssi_directive_scanner_top test failed");
         $finish;
      end
   end

   initial begin
      int directed_n;
      int pick;
      int len;

      // directed: byte extremes, end in ground, prefix mismatches after one and after four
      // held bytes, no rescan, dash chains before the closer, dropped prefix, abandoned body
      push_byte(8'h00);
      push_byte(8'hFF);
      push_eoi();
      push_str("<<!--x");
      push_str("<!--x");
      push_str("<!--#-a--->");
      push_str("<!-");
      push_eoi();
      push_str("<!--#z");
      push_eoi();
      directed_n = doc_items.size();

      // random: directives with random bodies, plus text and broken openers
      while (doc_items.size() < directed_n + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1: begin
               len = $urandom_range(1, 6);
               repeat (len) push_byte(8'($urandom_range(0, 255)));
            end
            7: begin
               len = $urandom_range(1, 4);
               for (int k = 0; k < len; k++)
                  push_byte((k == 0) ? CH_LT : (k == 1) ? CH_BANG : CH_DASH);
               push_byte(($urandom_range(0, 1) == 0) ? CH_LT : 8'($urandom_range(0, 255)));
            end
            8: begin
               len = $urandom_range(0, 4);
               for (int k = 0; k < len; k++)
                  push_byte((k == 0) ? CH_LT : (k == 1) ? CH_BANG : CH_DASH);
               push_eoi();
            end
            9: begin
               len = $urandom_range(1, 5);
               repeat (len) push_byte(($urandom_range(0, 1) == 0) ? CH_LT : body_char());
            end
            default: begin
               push_str("<!--#");
               len = $urandom_range(0, 12);
               repeat (len) push_byte(body_char());
               case ($urandom_range(0, 5))
                  0:       push_eoi();
                  1:       push_str("->");
                  default: push_str("-->");
               endcase
            end
         endcase
      end
      push_str("ok");

      wait (reset == 1'b0);
      while (doc_items.size() > 0 || req_valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d items and %0d results: %0d directives closed, %0d abandoned",
               accepted_items, results_seen, closed_count, abandoned_count);
      $display("%0d body bytes fell past the cut, %0d mismatches", cut_count, fail_count);
      if (fail_count == 0) begin
         $display("ssi_directive_scanner_top test passed");
      end else begin
         $display("ssi_directive_scanner_top test failed");
      end
      $finish;
   end

   // reset held at the start only
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
